// ===== rtl/psg_pkg.sv =====
// Shared types, register map, constants and the volume table of the sound generator.
package psg_pkg;

	// Item operation codes.
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// Register map.
	localparam logic [3:0] REG_NOISE     = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_VOL_A     = 4'd8;
	localparam logic [3:0] REG_ENV_LO    = 4'd11;
	localparam logic [3:0] REG_ENV_HI    = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

	localparam int NUM_REGS = 16;
	localparam int NUM_CH = 3;

	// Widths of the counters and periods.
	localparam int TONE_CNT_W = 15;
	localparam int TONE_PER_W = 12;
	localparam int NOISE_CNT_W = 8;
	localparam int NOISE_PER_W = 5;
	localparam int ENV_CNT_W = 19;
	localparam int ENV_PER_W = 16;
	localparam int LFSR_W = 17;

	// Mixer and output widths.
	localparam int VOL_W = 15;
	localparam int MIX_W = 16;
	localparam int SAMPLE_W = 15;

	// Largest sample: full volume on all three channels, divided by three.
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 15'd21760;

	// Division by three as a multiply by ceil(2^17 / 3) and a shift by 17.
	localparam logic [15:0] DIV3_RECIP = 16'd43691;
	localparam int DIV3_SHIFT = 17;

	// Default clock prescale of every period.
	localparam int PRESCALE_DEF = 8;

	// Envelope control from the item stage to the envelope unit.
	typedef struct packed {
		logic       tick;
		logic       restart;
		logic [3:0] shape;
	} env_ctrl_t;

	// Logarithmic volume table.
	function automatic logic [VOL_W-1:0] vol_level(input logic [3:0] lvl);
		logic [VOL_W-1:0] v;
		unique case (lvl)
			4'd0:  v = 15'd0;
			4'd1:  v = 15'd170;
			4'd2:  v = 15'd240;
			4'd3:  v = 15'd340;
			4'd4:  v = 15'd480;
			4'd5:  v = 15'd680;
			4'd6:  v = 15'd960;
			4'd7:  v = 15'd1360;
			4'd8:  v = 15'd1920;
			4'd9:  v = 15'd2720;
			4'd10: v = 15'd3840;
			4'd11: v = 15'd5440;
			4'd12: v = 15'd7680;
			4'd13: v = 15'd10880;
			4'd14: v = 15'd15360;
			default: v = 15'd21760;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/psg_tone_noise_envelope_top.sv =====
// Top level of the three-channel tone, noise and envelope sound generator.
//
// Usage:
//   Items arrive on the item channel (item_valid, item_stall) with fields
//   operation, reg_index and value. A write item stores value in one of the
//   sixteen sound registers and gives no result; writing the shape register
//   restarts the envelope. A tick item advances the noise, envelope and tone
//   counters and gives one sample on the sample channel (sample_valid,
//   sample_stall).
//   A tick passes from the item stage register to the mix register and then
//   to the output register, from which its sample is offered.
//   Throughput: one item per cycle; every stage advances while the one after it
//   is empty or moving, so the input keeps flowing while a sample waits.
//   A write item never waits on the sample side.
//   When the receiver stalls, the sample holds and ticks fill the two free
//   stages behind it before item_stall rises.
//   Reset clears the register file, all counters and the envelope, and loads
//   the noise shift register with one; no samples are pending after reset.
module psg_tone_noise_envelope_top #(
	parameter int PRESCALE = psg_pkg::PRESCALE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             operation,
	input  logic [3:0]                       reg_index,
	input  logic [7:0]                       value,
	output logic                             sample_valid,
	input  logic                             sample_stall,
	output logic [psg_pkg::SAMPLE_W-1:0]     sample
);

	// Item stage.
	logic             valid_s1;
	psg_pkg::op_t     op_s1;
	logic [3:0]       idx_s1;
	logic [7:0]       val_s1;

	// Mix stage.
	logic                      valid_s2;
	logic [psg_pkg::MIX_W-1:0] mix_s2;

	// Output register.
	logic                         out_valid_q;
	logic [psg_pkg::SAMPLE_W-1:0] sample_q;

	logic adv1;
	logic adv2;
	logic is_tick;
	logic is_write;

	logic [7:0] regs_q [psg_pkg::NUM_REGS];

	logic                          noise_hit;
	logic [psg_pkg::LFSR_W-1:0]    lfsr_q;
	logic                          noise_bit_q;
	logic                          noise_bit_next;
	logic [psg_pkg::NUM_CH-1:0]    tone_hit;
	logic [psg_pkg::NUM_CH-1:0]    phase_q;
	logic [psg_pkg::NUM_CH-1:0]    phase_next;
	logic [3:0]                    env_level;
	psg_pkg::env_ctrl_t            env_ctrl;
	logic [psg_pkg::MIX_W-1:0]     mix;
	logic [31:0]                   div_prod;

	// Stage handshakes: a write never needs the later stages.
	assign is_tick = (op_s1 == psg_pkg::OP_TICK);
	assign is_write = (op_s1 == psg_pkg::OP_WRITE);
	assign adv2 = valid_s2 && (!out_valid_q || !sample_stall);
	assign adv1 = valid_s1 && (is_write || !valid_s2 || adv2);
	assign item_stall = valid_s1 && !adv1;

	// Item stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1 <= psg_pkg::op_t'(operation);
			idx_s1 <= reg_index;
			val_s1 <= value;
		end
	end

	// Sound register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < psg_pkg::NUM_REGS; r++) begin
				regs_q[r] <= '0;
			end
		end else if (adv1 && is_write) begin
			regs_q[idx_s1] <= val_s1;
		end
	end

	// Noise period counter and shift register.
	psg_counter #(
		.CNT_W    (psg_pkg::NOISE_CNT_W),
		.PER_W    (psg_pkg::NOISE_PER_W),
		.PRESCALE (PRESCALE)
	) u_noise_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv1 && is_tick),
		.clr    (1'b0),
		.period (regs_q[psg_pkg::REG_NOISE][psg_pkg::NOISE_PER_W-1:0]),
		.hit    (noise_hit)
	);

	assign noise_bit_next = noise_hit ? lfsr_q[1] : noise_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= psg_pkg::LFSR_W'(1);
			noise_bit_q <= 1'b0;
		end else if (adv1 && is_tick && noise_hit) begin
			lfsr_q <= {lfsr_q[0] ^ lfsr_q[3], lfsr_q[psg_pkg::LFSR_W-1:1]};
			noise_bit_q <= noise_bit_next;
		end
	end

	// Envelope unit.
	assign env_ctrl.tick = adv1 && is_tick;
	assign env_ctrl.restart = adv1 && is_write && (idx_s1 == psg_pkg::REG_ENV_SHAPE);
	assign env_ctrl.shape = val_s1[3:0];

	psg_env #(
		.PRESCALE (PRESCALE)
	) u_env (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (env_ctrl),
		.period     ({regs_q[psg_pkg::REG_ENV_HI], regs_q[psg_pkg::REG_ENV_LO]}),
		.level_next (env_level)
	);

	// Tone counters and square-wave phases.
	for (genvar c = 0; c < psg_pkg::NUM_CH; c++) begin : g_tone
		psg_counter #(
			.CNT_W    (psg_pkg::TONE_CNT_W),
			.PER_W    (psg_pkg::TONE_PER_W),
			.PRESCALE (PRESCALE)
		) u_tone_cnt (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv1 && is_tick),
			.clr    (1'b0),
			.period ({regs_q[2*c+1][3:0], regs_q[2*c]}),
			.hit    (tone_hit[c])
		);

		assign phase_next[c] = phase_q[c] ^ tone_hit[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv1 && is_tick) begin
			phase_q <= phase_next;
		end
	end

	// Gate and sum the channels with the updated phases, noise and envelope.
	psg_mix u_mix (
		.tone_phase (phase_next),
		.noise_bit  (noise_bit_next),
		.mixer      (regs_q[psg_pkg::REG_MIXER]),
		.vol_a      (regs_q[psg_pkg::REG_VOL_A]),
		.vol_b      (regs_q[psg_pkg::REG_VOL_A + 4'd1]),
		.vol_c      (regs_q[psg_pkg::REG_VOL_A + 4'd2]),
		.env_level  (env_level),
		.mix        (mix)
	);

	// Mix stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv2 || (adv1 && is_tick)) begin
			valid_s2 <= adv1 && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && is_tick) begin
			mix_s2 <= mix;
		end
	end

	// Divide by three through the reciprocal, exact for every mix value.
	assign div_prod = 32'(mix_s2) * 32'(psg_pkg::DIV3_RECIP);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !sample_stall) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sample_q <= div_prod[psg_pkg::DIV3_SHIFT +: psg_pkg::SAMPLE_W];
		end
	end

	assign sample_valid = out_valid_q;
	assign sample = sample_q;

	// A sample never exceeds full volume on all channels.
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (sample <= psg_pkg::SAMPLE_MAX))
		else $error("sample above full-scale level");

	// A write item in the item stage always moves on.
	a_write_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_write) |-> !item_stall)
		else $error("write item stalled");

	// A blocked mix stage keeps its sample.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv2) |=> (valid_s2 && $stable(mix_s2)))
		else $error("mix stage lost or changed a blocked sample");

	// The input stalls only while both later stages are full and the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s2 && out_valid_q && sample_stall))
		else $error("input stalled with room downstream");

endmodule

// ===== rtl/psg_counter.sv =====
// Prescaled period counter that flags when its period is reached.
module psg_counter #(
	parameter int CNT_W    = 15,
	parameter int PER_W    = 12,
	parameter int PRESCALE = psg_pkg::PRESCALE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             clr,
	input  logic [PER_W-1:0] period,
	output logic             hit
);

	localparam int PS_W = $clog2(PRESCALE + 1);
	localparam int CMP_W = (CNT_W + 1 > PER_W + PS_W) ? CNT_W + 1 : PER_W + PS_W;

	logic [CNT_W-1:0] count_q;
	logic [PER_W-1:0] per_eff;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] inc;
	logic [CNT_W-1:0] count_next;

	// A period of zero counts as one; compare the increment before truncation.
	always_comb begin
		per_eff = (period == '0) ? PER_W'(1) : period;
		limit = CMP_W'(per_eff) * CMP_W'(PRESCALE);
		inc = CMP_W'(count_q) + CMP_W'(1);
		hit = (inc >= limit);
		count_next = hit ? '0 : inc[CNT_W-1:0];
	end

	// Counter register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_next;
		end
	end

endmodule

// ===== rtl/psg_env.sv =====
// Envelope generator: period counter, level and shape flags.
module psg_env #(
	parameter int PRESCALE = psg_pkg::PRESCALE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psg_pkg::env_ctrl_t               ctrl,
	input  logic [psg_pkg::ENV_PER_W-1:0]    period,
	output logic [3:0]                       level_next
);

	logic       hit;
	logic       step;
	logic [3:0] level_q;
	logic [3:0] flags_q;
	logic [3:0] flags_next;
	logic       at_end;

	psg_counter #(
		.CNT_W    (psg_pkg::ENV_CNT_W),
		.PER_W    (psg_pkg::ENV_PER_W),
		.PRESCALE (PRESCALE)
	) u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (ctrl.tick),
		.clr    (ctrl.restart),
		.period (period),
		.hit    (hit)
	);

	assign step = ctrl.tick && hit;

	// Step or restart; flags are hold, alternate, attack, continue from bit 0 up.
	always_comb begin
		level_next = level_q;
		flags_next = flags_q;
		at_end = 1'b0;
		if (ctrl.restart) begin
			flags_next = ctrl.shape;
			level_next = ctrl.shape[2] ? 4'd15 : 4'd0;
		end else if (step && !flags_q[0]) begin
			if (flags_q[2]) begin
				at_end = (level_q == 4'd15);
				if (!at_end) begin
					level_next = level_q + 4'd1;
				end
			end else begin
				at_end = (level_q == 4'd0);
				if (!at_end) begin
					level_next = level_q - 4'd1;
				end
			end
			if (at_end) begin
				if (!flags_q[3]) begin
					flags_next[0] = 1'b1;
				end
				if (flags_q[1]) begin
					flags_next[2] = ~flags_q[2];
				end
			end
		end
	end

	// Level and flag registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			flags_q <= '0;
		end else begin
			level_q <= level_next;
			flags_q <= flags_next;
		end
	end

endmodule

// ===== rtl/psg_mix.sv =====
// Channel gating and volume summing of the three channels.
module psg_mix (
	input  logic [psg_pkg::NUM_CH-1:0] tone_phase,
	input  logic                       noise_bit,
	input  logic [7:0]                 mixer,
	input  logic [7:0]                 vol_a,
	input  logic [7:0]                 vol_b,
	input  logic [7:0]                 vol_c,
	input  logic [3:0]                 env_level,
	output logic [psg_pkg::MIX_W-1:0]  mix
);

	logic [7:0]                vol_reg [psg_pkg::NUM_CH];
	logic [psg_pkg::VOL_W-1:0] ch_vol  [psg_pkg::NUM_CH];

	assign vol_reg[0] = vol_a;
	assign vol_reg[1] = vol_b;
	assign vol_reg[2] = vol_c;

	// A mixer bit low enables that source; a channel sounds when both gates are high.
	always_comb begin
		for (int c = 0; c < psg_pkg::NUM_CH; c++) begin
			if ((mixer[c] || tone_phase[c]) && (mixer[c + psg_pkg::NUM_CH] || noise_bit)) begin
				ch_vol[c] = psg_pkg::vol_level(vol_reg[c][4] ? env_level : vol_reg[c][3:0]);
			end else begin
				ch_vol[c] = '0;
			end
		end
		mix = psg_pkg::MIX_W'(ch_vol[0]) + psg_pkg::MIX_W'(ch_vol[1])
			+ psg_pkg::MIX_W'(ch_vol[2]);
	end

endmodule
